// ===== rtl/core/jtdtm_pkg.sv =====
// ----------------------------------------------------------------------------
// JTAG DTM package
// Shared constants, TAP state encoding and the records passed between the
// TAP controller, the data register unit and the top level.
// ----------------------------------------------------------------------------
package jtdtm_pkg;

  localparam int ADDR_BITS  = 8;
  localparam int IR_WIDTH   = 5;
  localparam int DATA_W     = 32;
  localparam int DMI_LEN    = ADDR_BITS + DATA_W + 2;
  localparam int ADDR_OUT_W = 8;
  localparam int TAP_IDX_W  = 4;

  typedef logic [IR_WIDTH-1:0] ir_t;

  localparam ir_t INSTR_BYPASS = 5'h00;
  localparam ir_t INSTR_IDCODE = 5'h01;
  localparam ir_t INSTR_DTMCS  = 5'h10;
  localparam ir_t INSTR_DMI    = 5'h11;

  // Item opcodes on the input channel.
  localparam logic OPC_EDGE = 1'b0;
  localparam logic OPC_RESP = 1'b1;

  typedef enum logic [1:0] {
    DMI_OP_NOP  = 2'd0,
    DMI_OP_RD   = 2'd1,
    DMI_OP_WR   = 2'd2,
    DMI_OP_RSVD = 2'd3
  } dmi_op_t;

  // DTMCS: version 1, abits in bits 9:4, idle hint 0.
  localparam logic [DATA_W-1:0] DTMCS_VALUE =
    DATA_W'(1) | (DATA_W'(ADDR_BITS % 64) << 4);

  typedef enum logic [15:0] {
    TAP_RESET  = 16'h0001,
    TAP_IDLE   = 16'h0002,
    TAP_SEL_DR = 16'h0004,
    TAP_CAP_DR = 16'h0008,
    TAP_SH_DR  = 16'h0010,
    TAP_X1_DR  = 16'h0020,
    TAP_PA_DR  = 16'h0040,
    TAP_X2_DR  = 16'h0080,
    TAP_UP_DR  = 16'h0100,
    TAP_SEL_IR = 16'h0200,
    TAP_CAP_IR = 16'h0400,
    TAP_SH_IR  = 16'h0800,
    TAP_X1_IR  = 16'h1000,
    TAP_PA_IR  = 16'h2000,
    TAP_X2_IR  = 16'h4000,
    TAP_UP_IR  = 16'h8000
  } tap_state_t;

  typedef struct packed {
    logic       step;
    tap_state_t cur;
    tap_state_t nxt;
  } tap_step_t;

  typedef struct packed {
    logic                  valid;
    logic                  write;
    logic [ADDR_OUT_W-1:0] addr;
    logic [DATA_W-1:0]     data;
  } dmi_req_t;

  // Standard IEEE 1149.1 TAP transition table.
  function automatic tap_state_t tap_next(tap_state_t s, logic tms);
    tap_state_t n;
    n = TAP_RESET;
    unique case (s)
      TAP_RESET:  n = tms ? TAP_RESET  : TAP_IDLE;
      TAP_IDLE:   n = tms ? TAP_SEL_DR : TAP_IDLE;
      TAP_SEL_DR: n = tms ? TAP_SEL_IR : TAP_CAP_DR;
      TAP_CAP_DR: n = tms ? TAP_X1_DR  : TAP_SH_DR;
      TAP_SH_DR:  n = tms ? TAP_X1_DR  : TAP_SH_DR;
      TAP_X1_DR:  n = tms ? TAP_UP_DR  : TAP_PA_DR;
      TAP_PA_DR:  n = tms ? TAP_X2_DR  : TAP_PA_DR;
      TAP_X2_DR:  n = tms ? TAP_UP_DR  : TAP_SH_DR;
      TAP_UP_DR:  n = tms ? TAP_SEL_DR : TAP_IDLE;
      TAP_SEL_IR: n = tms ? TAP_RESET  : TAP_CAP_IR;
      TAP_CAP_IR: n = tms ? TAP_X1_IR  : TAP_SH_IR;
      TAP_SH_IR:  n = tms ? TAP_X1_IR  : TAP_SH_IR;
      TAP_X1_IR:  n = tms ? TAP_UP_IR  : TAP_PA_IR;
      TAP_PA_IR:  n = tms ? TAP_X2_IR  : TAP_PA_IR;
      TAP_X2_IR:  n = tms ? TAP_UP_IR  : TAP_SH_IR;
      TAP_UP_IR:  n = tms ? TAP_SEL_DR : TAP_IDLE;
      default:    n = TAP_RESET;
    endcase
    return n;
  endfunction

  // Conventional state number, 0 = Test-Logic-Reset ... 15 = Update-IR.
  function automatic logic [TAP_IDX_W-1:0] tap_index(tap_state_t s);
    logic [TAP_IDX_W-1:0] idx;
    idx = '0;
    unique case (s)
      TAP_RESET:  idx = 4'd0;
      TAP_IDLE:   idx = 4'd1;
      TAP_SEL_DR: idx = 4'd2;
      TAP_CAP_DR: idx = 4'd3;
      TAP_SH_DR:  idx = 4'd4;
      TAP_X1_DR:  idx = 4'd5;
      TAP_PA_DR:  idx = 4'd6;
      TAP_X2_DR:  idx = 4'd7;
      TAP_UP_DR:  idx = 4'd8;
      TAP_SEL_IR: idx = 4'd9;
      TAP_CAP_IR: idx = 4'd10;
      TAP_SH_IR:  idx = 4'd11;
      TAP_X1_IR:  idx = 4'd12;
      TAP_PA_IR:  idx = 4'd13;
      TAP_X2_IR:  idx = 4'd14;
      TAP_UP_IR:  idx = 4'd15;
      default:    idx = '0;
    endcase
    return idx;
  endfunction

endpackage

// ===== rtl/core/jtdtm_if.sv =====
// ----------------------------------------------------------------------------
// JTAG DTM channel interfaces
// Valid/ready channels for input words, result words and configuration.
// ----------------------------------------------------------------------------
interface jtdtm_in_if import jtdtm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              opcode;
  logic              tms;
  logic              tdi;
  logic [DATA_W-1:0] read_data;

  modport source (output valid, output opcode, output tms, output tdi,
                  output read_data, input ready);
  modport sink   (input valid, input opcode, input tms, input tdi,
                  input read_data, output ready);
endinterface

interface jtdtm_out_if import jtdtm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  tdo;
  logic                  dmi_req_valid;
  logic                  dmi_req_write;
  logic [ADDR_OUT_W-1:0] dmi_address;
  logic [DATA_W-1:0]     dmi_write_data;
  logic [TAP_IDX_W-1:0]  tap_now;

  modport source (output valid, output tdo, output dmi_req_valid,
                  output dmi_req_write, output dmi_address,
                  output dmi_write_data, output tap_now, input ready);
  modport sink   (input valid, input tdo, input dmi_req_valid,
                  input dmi_req_write, input dmi_address,
                  input dmi_write_data, input tap_now, output ready);
endinterface

interface jtdtm_cfg_if import jtdtm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/jtdtm_tap_ctrl.sv =====
// ----------------------------------------------------------------------------
// JTAG DTM TAP controller
// Holds the 16-state TAP machine and steps it on each accepted edge word.
// ----------------------------------------------------------------------------
module jtdtm_tap_ctrl import jtdtm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_en,
  input  logic      tms,
  output tap_step_t tap
);

  tap_state_t state_r;
  tap_state_t state_nxt;

  always_comb begin
    state_nxt = step_en ? tap_next(state_r, tms) : state_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= TAP_RESET;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign tap = '{step: step_en, cur: state_r, nxt: state_nxt};

  // Edges with TMS high lead from anywhere into Test-Logic-Reset; an edge
  // with TMS high keeps the machine there.
  a_reset_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && tms && state_r == TAP_RESET) |=> (state_r == TAP_RESET))
    else $error("TAP left Test-Logic-Reset with TMS high");

  a_no_step_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !step_en |=> $stable(state_r))
    else $error("TAP state moved without an edge word");

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("TAP state is not one-hot");

endmodule

// ===== rtl/core/jtdtm_dr_unit.sv =====
// ----------------------------------------------------------------------------
// JTAG DTM register unit
// Instruction register, shared capture/shift register, DMI response hold and
// the DMI request decode at Update-DR.
// ----------------------------------------------------------------------------
module jtdtm_dr_unit import jtdtm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  tap_step_t         tap,
  input  logic              tdi,
  input  logic              resp_en,
  input  logic [DATA_W-1:0] resp_data,
  input  logic [DATA_W-1:0] id_code,
  output logic              shift_lsb,
  output dmi_req_t          req
);

  ir_t                ir_r;
  ir_t                ir_nxt;
  logic [DMI_LEN-1:0] shift_r;
  logic [DMI_LEN-1:0] shift_nxt;
  logic [DATA_W-1:0]  hold_r;
  dmi_op_t            op;

  assign op = dmi_op_t'(shift_r[1:0]);

  always_comb begin
    ir_nxt    = ir_r;
    shift_nxt = shift_r;
    if (tap.step) begin
      case (tap.cur)
        TAP_RESET:  ir_nxt = INSTR_IDCODE;
        TAP_CAP_IR: shift_nxt = DMI_LEN'(ir_r);
        TAP_SH_IR:  shift_nxt = DMI_LEN'({tdi, shift_r[IR_WIDTH-1:1]});
        TAP_UP_IR:  ir_nxt = shift_r[IR_WIDTH-1:0];
        TAP_CAP_DR: begin
          case (ir_r)
            INSTR_IDCODE: shift_nxt = DMI_LEN'(id_code);
            INSTR_DTMCS:  shift_nxt = DMI_LEN'(DTMCS_VALUE);
            INSTR_DMI:    shift_nxt = DMI_LEN'({hold_r, 2'b00});
            default:      shift_nxt = '0;
          endcase
        end
        TAP_SH_DR: begin
          case (ir_r) inside
            INSTR_IDCODE, INSTR_DTMCS:
              shift_nxt = DMI_LEN'({tdi, shift_r[DATA_W-1:1]});
            INSTR_DMI: shift_nxt = {tdi, shift_r[DMI_LEN-1:1]};
            default:   shift_nxt = DMI_LEN'(tdi);
          endcase
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    req = '0;
    if (tap.step && tap.cur == TAP_UP_DR && ir_r == INSTR_DMI &&
        (op == DMI_OP_RD || op == DMI_OP_WR)) begin
      req.valid = 1'b1;
      req.write = (op == DMI_OP_WR);
      req.addr  = ADDR_OUT_W'(shift_r[DMI_LEN-1 -: ADDR_BITS]);
      req.data  = (op == DMI_OP_WR) ? shift_r[DATA_W+1:2] : '0;
    end
  end

  assign shift_lsb = shift_nxt[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_r    <= INSTR_BYPASS;
      shift_r <= '0;
      hold_r  <= '0;
    end else begin
      ir_r    <= ir_nxt;
      shift_r <= shift_nxt;
      if (resp_en) begin
        hold_r <= resp_data;
      end
    end
  end

  a_req_origin: assert property (@(posedge clk) disable iff (!rst_n)
    req.valid |-> (tap.step && tap.cur == TAP_UP_DR && ir_r == INSTR_DMI))
    else $error("DMI request outside Update-DR under DMI");

  a_read_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (req.valid && !req.write) |-> (req.data == '0))
    else $error("DMI read request carries write data");

  a_reset_loads_idcode: assert property (@(posedge clk) disable iff (!rst_n)
    (tap.step && tap.cur == TAP_RESET) |=> (ir_r == INSTR_IDCODE))
    else $error("Test-Logic-Reset did not select IDCODE");

endmodule

// ===== rtl/core/jtag_tap_riscv_dtm_unit.sv =====
// ----------------------------------------------------------------------------
// JTAG TAP with RISC-V debug transport
// Top level: input acceptance, configuration register and result register.
// ----------------------------------------------------------------------------
// Each input word is either one rising TCK edge (opcode 0, with TMS and TDI)
// or a DMI read response (opcode 1, with the read data). The block takes one
// word per clock cycle, and each result word comes from a register: the
// TAP controller, instruction register and shift register update at the edge
// that accepts the word, and the result register carries TDO, any DMI request
// issued at Update-DR and the new TAP state number. The single result
// register is the only thing that limits the rate; input ready drops only
// while a result waits and the output side is stalled. A response word loads
// the data that the next DMI capture returns (with op 0) and repeats the
// previous TDO and the current TAP state. The IDCODE value is written through
// the configuration channel, which is always ready; write it only while no
// word is in flight.
module jtag_tap_riscv_dtm_unit import jtdtm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  jtdtm_in_if.sink    in_if,
  jtdtm_out_if.source out_if,
  jtdtm_cfg_if.sink   cfg_if
);

  logic                 accept;
  logic                 step_en;
  logic                 resp_en;
  tap_step_t            tap;
  logic                 shift_lsb;
  dmi_req_t             req;

  logic [DATA_W-1:0]    id_code_r;
  logic                 tdo_r;
  logic                 tdo_nxt;
  logic                 out_valid_r;
  dmi_req_t             req_r;
  logic [TAP_IDX_W-1:0] tap_now_r;

  // A new word may enter whenever the result register is empty or being
  // drained in this same cycle.
  assign in_if.ready = !out_valid_r || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;
  assign step_en     = accept && (in_if.opcode == OPC_EDGE);
  assign resp_en     = accept && (in_if.opcode == OPC_RESP);

  assign cfg_if.ready = 1'b1;

  jtdtm_tap_ctrl u_tap (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .tms     (in_if.tms),
    .tap     (tap)
  );

  jtdtm_dr_unit u_dr (
    .clk       (clk),
    .rst_n     (rst_n),
    .tap       (tap),
    .tdi       (in_if.tdi),
    .resp_en   (resp_en),
    .resp_data (in_if.read_data),
    .id_code   (id_code_r),
    .shift_lsb (shift_lsb),
    .req       (req)
  );

  // TDO follows bit 0 of the updated shifter only in the two shift states;
  // a response word leaves it as it was.
  always_comb begin
    tdo_nxt = tdo_r;
    if (step_en) begin
      tdo_nxt = (tap.nxt == TAP_SH_DR || tap.nxt == TAP_SH_IR) ? shift_lsb : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_code_r   <= DATA_W'(1);
      tdo_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        id_code_r <= cfg_if.data;
      end
      tdo_r <= tdo_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload needs no reset: it is qualified by out_valid_r.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r     <= req;
      tap_now_r <= tap_index(tap.nxt);
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.tdo            = tdo_r;
  assign out_if.dmi_req_valid  = req_r.valid;
  assign out_if.dmi_req_write  = req_r.write;
  assign out_if.dmi_address    = req_r.addr;
  assign out_if.dmi_write_data = req_r.data;
  assign out_if.tap_now        = tap_now_r;

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("Accepted word produced no result");

  a_tap_now_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (tap_now_r == tap_index(tap.cur)))
    else $error("Reported TAP state differs from controller state");

  a_resp_keeps_tdo: assert property (@(posedge clk) disable iff (!rst_n)
    resp_en |=> (tdo_r == $past(tdo_r)))
    else $error("Response word changed TDO");

endmodule

// ===== dv/jtag_tap_riscv_dtm_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// JTAG TAP / RISC-V DTM unit testbench
// Runs TCK-edge words and DMI response words through the unit, with random
// gaps on both channels and one long output stall. A behavioral model of the
// TAP, its instruction register and its shifter predicts every result word,
// and each result word is checked field by field against that prediction.
// ----------------------------------------------------------------------------
module jtag_tap_riscv_dtm_unit_tb;
  import jtdtm_pkg::*;

  // TAP states by their conventional number, as reported on tap_now.
  typedef enum logic [3:0] {
    TS_TLR = 4'd0, TS_RTI, TS_SEL_DR, TS_CAP_DR, TS_SH_DR, TS_EX1_DR, TS_PAU_DR,
    TS_EX2_DR, TS_UPD_DR, TS_SEL_IR, TS_CAP_IR, TS_SH_IR, TS_EX1_IR, TS_PAU_IR,
    TS_EX2_IR, TS_UPD_IR
  } tap_idx_t;

  // One result word as the unit should present it.
  typedef struct packed {
    logic                  tdo;
    logic                  req_valid;
    logic                  req_write;
    logic [ADDR_OUT_W-1:0] addr;
    logic [DATA_W-1:0]     wdata;
    logic [TAP_IDX_W-1:0]  tap;
  } tap_result_t;

  logic clk;
  logic rst_n;

  jtdtm_in_if  in_if ();
  jtdtm_out_if out_if ();
  jtdtm_cfg_if cfg_if ();

  jtag_tap_riscv_dtm_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // Model state. It starts in its reset condition, since reset is applied
  // exactly once at the start of the run.
  tap_idx_t           tap_q       = TS_TLR;
  ir_t                ir_q        = '0;
  logic [DMI_LEN-1:0] shifter_q   = '0;
  logic [DATA_W-1:0]  resp_hold_q = '0;
  logic               tdo_q       = 1'b0;
  logic [DATA_W-1:0]  idcode_q    = 32'd1;

  // Result words predicted for accepted input words, oldest first.
  tap_result_t dtm_out_q[$];

  int errors     = 0;
  int words_sent = 0;

  // Stimulus controls. gaps_on lets both channels idle at random; out_hold
  // asks the result side for one long stall; sprinkle_resp mixes response
  // words in among the TCK-edge words.
  bit gaps_on       = 1'b1;
  bit sprinkle_resp = 1'b0;
  int out_hold      = 0;

  // Where the stimulus believes the TAP is, and which instruction it last
  // scanned in. Only used to steer the stimulus, never for checking.
  tap_idx_t drive_tap = TS_TLR;
  ir_t      drive_ir  = INSTR_IDCODE;

  // --------------------------------------------------------------------------
  // Clock and run limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The run limit allows far more time than the slowest legal run needs.
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Model of the TAP
  // --------------------------------------------------------------------------
  function automatic tap_idx_t tap_advance(tap_idx_t s, logic tms);
    case (s)
      TS_TLR:    return tms ? TS_TLR    : TS_RTI;
      TS_RTI:    return tms ? TS_SEL_DR : TS_RTI;
      TS_SEL_DR: return tms ? TS_SEL_IR : TS_CAP_DR;
      TS_CAP_DR: return tms ? TS_EX1_DR : TS_SH_DR;
      TS_SH_DR:  return tms ? TS_EX1_DR : TS_SH_DR;
      TS_EX1_DR: return tms ? TS_UPD_DR : TS_PAU_DR;
      TS_PAU_DR: return tms ? TS_EX2_DR : TS_PAU_DR;
      TS_EX2_DR: return tms ? TS_UPD_DR : TS_SH_DR;
      TS_UPD_DR: return tms ? TS_SEL_DR : TS_RTI;
      TS_SEL_IR: return tms ? TS_TLR    : TS_CAP_IR;
      TS_CAP_IR: return tms ? TS_EX1_IR : TS_SH_IR;
      TS_SH_IR:  return tms ? TS_EX1_IR : TS_SH_IR;
      TS_EX1_IR: return tms ? TS_UPD_IR : TS_PAU_IR;
      TS_PAU_IR: return tms ? TS_EX2_IR : TS_PAU_IR;
      TS_EX2_IR: return tms ? TS_UPD_IR : TS_SH_IR;
      TS_UPD_IR: return tms ? TS_SEL_DR : TS_RTI;
      default:   return TS_TLR;
    endcase
  endfunction

  // Length of the data register that an instruction selects. Instructions
  // the unit does not know select the one-bit bypass register.
  function automatic int dr_bits(ir_t ir);
    if (ir == INSTR_IDCODE || ir == INSTR_DTMCS) return DATA_W;
    if (ir == INSTR_DMI) return DMI_LEN;
    return 1;
  endfunction

  // Applies one accepted input word to the model and returns the result word
  // it produces. The action belongs to the state the edge is taken in; the
  // state then steps on tms, and tdo follows the new state.
  function automatic tap_result_t advance_dtm(logic opc, logic tms, logic tdi,
                                              logic [DATA_W-1:0] rdata);
    tap_result_t        r;
    logic [DMI_LEN-1:0] mask;
    int                 len;
    dmi_op_t            op;
    r = '0;
    if (opc == OPC_RESP) begin
      // A response only parks its data for the next DMI capture.
      resp_hold_q = rdata;
    end else begin
      case (tap_q)
        TS_TLR: ir_q = INSTR_IDCODE;
        TS_CAP_IR: shifter_q = DMI_LEN'(ir_q);
        TS_SH_IR: shifter_q = DMI_LEN'({tdi, shifter_q[IR_WIDTH-1:1]});
        TS_UPD_IR: ir_q = shifter_q[IR_WIDTH-1:0];
        TS_CAP_DR: begin
          if (ir_q == INSTR_IDCODE)
            shifter_q = DMI_LEN'(idcode_q);
          else if (ir_q == INSTR_DTMCS)
            shifter_q = DMI_LEN'(DATA_W'(1) | (DATA_W'(ADDR_BITS & 6'h3f) << 4));
          else if (ir_q == INSTR_DMI)
            shifter_q = DMI_LEN'({resp_hold_q, 2'b00});
          else
            shifter_q = '0;
        end
        TS_SH_DR: begin
          // tdi enters at the top of the selected register, not the shifter.
          len            = dr_bits(ir_q);
          mask           = {DMI_LEN{1'b1}} >> (DMI_LEN - len);
          shifter_q      = shifter_q >> 1;
          shifter_q[len-1] = tdi;
          shifter_q      = shifter_q & mask;
        end
        TS_UPD_DR: begin
          // Only DMI issues requests, and only for the read and write ops.
          // DTMCS updates are dropped on the floor.
          op = dmi_op_t'(shifter_q[1:0]);
          if (ir_q == INSTR_DMI && (op == DMI_OP_RD || op == DMI_OP_WR)) begin
            r.req_valid = 1'b1;
            r.req_write = (op == DMI_OP_WR);
            r.addr      = ADDR_OUT_W'(shifter_q[DATA_W+2 +: ADDR_BITS]);
            if (op == DMI_OP_WR) r.wdata = shifter_q[2 +: DATA_W];
          end
        end
        default: ;
      endcase
      tap_q = tap_advance(tap_q, tms);
      tdo_q = (tap_q == TS_SH_DR || tap_q == TS_SH_IR) ? shifter_q[0] : 1'b0;
    end
    // A response word repeats the last tdo and the present state.
    r.tdo = tdo_q;
    r.tap = tap_q;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  function automatic void match_field(string what, logic [DATA_W-1:0] want,
                                      logic [DATA_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    end
  endfunction

  // Input words are predicted as they are accepted, so the queue always
  // holds the result words still owed by the unit. Prediction comes first so
  // that even a combinational result would find its expectation waiting.
  always @(posedge clk) begin : result_check
    tap_result_t want;
    tap_result_t got;
    if (rst_n) begin
      if (in_if.valid && in_if.ready)
        dtm_out_q.push_back(advance_dtm(in_if.opcode, in_if.tms, in_if.tdi,
                                        in_if.read_data));
      if (out_if.valid && out_if.ready) begin
        got.tdo       = out_if.tdo;
        got.req_valid = out_if.dmi_req_valid;
        got.req_write = out_if.dmi_req_write;
        got.addr      = out_if.dmi_address;
        got.wdata     = out_if.dmi_write_data;
        got.tap       = out_if.tap_now;
        if (dtm_out_q.size() == 0) begin
          errors++;
          $display("%0t: result word with none outstanding, expected none, actual %h",
                   $time, got);
        end else begin
          want = dtm_out_q.pop_front();
          match_field("tdo", want.tdo, got.tdo);
          match_field("dmi_req_valid", want.req_valid, got.req_valid);
          match_field("dmi_req_write", want.req_write, got.req_write);
          match_field("dmi_address", want.addr, got.addr);
          match_field("dmi_write_data", want.wdata, got.wdata);
          match_field("tap_now", want.tap, got.tap);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result side: random stalls per word, plus one long stall on request.
  // The long stall is counted here so the sender keeps offering words and
  // the unit has to push back on its input.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int wait_n;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (out_hold > 0) begin
        out_if.ready <= 1'b0;
        repeat (out_hold) @(posedge clk);
        out_hold = 0;
      end
      wait_n = gaps_on ? $urandom_range(0, 11) : 0;
      if (wait_n > 0) begin
        out_if.ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  function automatic logic [DATA_W-1:0] rand_data();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [63:0] dmi_frame(logic [ADDR_BITS-1:0] addr,
                                            logic [DATA_W-1:0] data, dmi_op_t op);
    return 64'({addr, data, op});
  endfunction

  // Sends one word and returns at the edge that accepts it. valid is left
  // high, so a following word with no gap goes out on the very next cycle.
  task automatic put_word(logic opc, logic tms, logic tdi, logic [DATA_W-1:0] rdata);
    int wait_n;
    wait_n = gaps_on ? $urandom_range(0, 11) : 0;
    if (wait_n > 0) begin
      in_if.valid <= 1'b0;
      repeat (wait_n) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.opcode    <= opc;
    in_if.tms       <= tms;
    in_if.tdi       <= tdi;
    in_if.read_data <= rdata;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    if (opc == OPC_EDGE) drive_tap = tap_advance(drive_tap, tms);
    words_sent++;
  endtask

  // One TCK edge, now and then preceded by a stray DMI response.
  task automatic tck(logic tms, logic tdi);
    if (sprinkle_resp && $urandom_range(0, 24) == 0)
      put_word(OPC_RESP, $urandom_range(0, 1), $urandom_range(0, 1), rand_data());
    put_word(OPC_EDGE, tms, tdi, $urandom());
  endtask

  // Walks to Run-Test/Idle, leaving any scan through its Update state.
  task automatic goto_idle();
    while (drive_tap != TS_RTI) begin
      case (drive_tap)
        TS_TLR, TS_UPD_DR, TS_UPD_IR, TS_SEL_IR: tck(1'b0, $urandom_range(0, 1));
        default: tck(1'b1, $urandom_range(0, 1));
      endcase
    end
  endtask

  // Shifts n bits, LSB first, leaving the TAP in Exit1. When paused is set,
  // the scan takes a detour through Pause and Exit2 at a random bit, unless the last bit is drawn.
  task automatic shift_bits(logic [63:0] bits, int n, bit paused);
    int brk;
    brk = paused ? $urandom_range(0, n - 1) : -1;
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) begin
        tck(1'b1, bits[i]);
      end else if (i == brk) begin
        tck(1'b1, bits[i]);
        tck(1'b0, $urandom_range(0, 1));
        repeat ($urandom_range(0, 3)) tck(1'b0, $urandom_range(0, 1));
        tck(1'b1, $urandom_range(0, 1));
        tck(1'b0, $urandom_range(0, 1));
      end else begin
        tck(1'b0, bits[i]);
      end
    end
  endtask

  task automatic scan_ir(ir_t v, bit paused);
    goto_idle();
    tck(1'b1, 1'b0);
    tck(1'b1, 1'b0);
    tck(1'b0, 1'b0);
    tck(1'b0, 1'b0);
    shift_bits(64'(v), IR_WIDTH, paused);
    tck(1'b1, 1'b0);
    tck(1'b0, 1'b0);
    drive_ir = v;
  endtask

  task automatic scan_dr(logic [63:0] bits, int n, bit paused);
    goto_idle();
    tck(1'b1, 1'b0);
    tck(1'b0, 1'b0);
    tck(1'b0, 1'b0);
    shift_bits(bits, n, paused);
    tck(1'b1, 1'b0);
    tck(1'b0, 1'b0);
  endtask

  // Stops sending and waits until every predicted result word has come back.
  // The first edge is waited out so the last acceptance is already counted.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (dtm_out_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // The IDCODE register may only change while nothing is in flight.
  task automatic write_idcode(logic [DATA_W-1:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    idcode_q = v;
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic ir_t pick_ir();
    case ($urandom_range(0, 5))
      0:       return INSTR_BYPASS;
      1:       return INSTR_IDCODE;
      2:       return INSTR_DTMCS;
      5:       return ir_t'($urandom_range(0, 31));
      default: return INSTR_DMI;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Hand-placed edges that visit all sixteen states, hold in Test-Logic-Reset
  // and bracket the run with response words of all ones and all zeros.
  task automatic test_tap_walk();
    put_word(OPC_RESP, 1'b1, 1'b1, '1);
    tck(1'b1, 1'b0);
    tck(1'b1, 1'b1);
    tck(1'b0, 1'b0);
    tck(1'b0, 1'b1);
    tck(1'b1, 1'b0);
    tck(1'b0, 1'b0);
    tck(1'b0, 1'b1);
    tck(1'b0, 1'b1);
    tck(1'b1, 1'b0);
    tck(1'b0, 1'b1);
    tck(1'b1, 1'b0);
    tck(1'b0, 1'b1);
    tck(1'b1, 1'b1);
    tck(1'b1, 1'b0);
    tck(1'b1, 1'b0);
    tck(1'b1, 1'b0);
    tck(1'b0, 1'b0);
    tck(1'b1, 1'b0);
    tck(1'b0, 1'b0);
    tck(1'b1, 1'b0);
    tck(1'b0, 1'b1);
    tck(1'b1, 1'b0);
    tck(1'b1, 1'b0);
    tck(1'b1, 1'b0);
    tck(1'b1, 1'b0);
    tck(1'b1, 1'b0);
    put_word(OPC_RESP, 1'b0, 1'b0, '0);
  endtask

  // IDCODE capture under several register values, the extremes included.
  // Every other pass relies on Test-Logic-Reset selecting IDCODE by itself.
  task automatic test_idcode();
    logic [DATA_W-1:0] vals[4];
    vals = '{'1, '0, $urandom(), 32'd1};
    for (int k = 0; k < 4; k++) begin
      drain_results();
      write_idcode(vals[k]);
      if (k % 2 == 0) begin
        repeat (5) tck(1'b1, $urandom_range(0, 1));
        drive_ir = INSTR_IDCODE;
      end else begin
        scan_ir(INSTR_IDCODE, $urandom_range(0, 1));
      end
      scan_dr({$urandom(), $urandom()}, DATA_W, $urandom_range(0, 1));
    end
  endtask

  // DTMCS reads back the same after a scan that tries to overwrite it.
  task automatic test_dtmcs();
    scan_ir(INSTR_DTMCS, 1'b0);
    scan_dr({$urandom(), $urandom()}, DATA_W, 1'b0);
    scan_dr({$urandom(), $urandom()}, DATA_W, 1'b1);
  endtask

  // BYPASS, then an instruction the unit does not decode, which must act
  // like BYPASS.
  task automatic test_bypass();
    ir_t v;
    scan_ir(INSTR_BYPASS, 1'b0);
    scan_dr({$urandom(), $urandom()}, 8, 1'b0);
    do v = ir_t'($urandom_range(0, 31));
    while (v == INSTR_BYPASS || v == INSTR_IDCODE || v == INSTR_DTMCS ||
           v == INSTR_DMI);
    scan_ir(v, 1'b1);
    scan_dr({$urandom(), $urandom()}, 8, 1'b1);
  endtask

  // Every DMI op, each followed by a response word so the next capture
  // shows the response data with op 0.
  task automatic test_dmi_access();
    dmi_op_t ops[4];
    ops = '{DMI_OP_RD, DMI_OP_WR, DMI_OP_NOP, DMI_OP_RSVD};
    scan_ir(INSTR_DMI, 1'b0);
    for (int k = 0; k < 4; k++) begin
      scan_dr(dmi_frame(ADDR_BITS'(rand_data()), rand_data(), ops[k]), DMI_LEN,
              (k % 2) == 1);
      put_word(OPC_RESP, $urandom_range(0, 1), $urandom_range(0, 1), rand_data());
    end
    scan_dr(dmi_frame('0, '0, DMI_OP_NOP), DMI_LEN, 1'b0);
  endtask

  // The result side stops for a long stretch while words keep coming, so
  // the result register fills and input ready has to drop.
  task automatic test_input_stall();
    gaps_on  = 1'b0;
    out_hold = 150;
    repeat (40) tck($urandom_range(0, 1), $urandom_range(0, 1));
    gaps_on  = 1'b1;
  endtask

  // Mostly well-formed IR and DR scans with random content, mixed with
  // response words, raw tms noise and TAP resets. Now and then the IDCODE
  // register changes between phases, and idle gaps come and go.
  task automatic test_random_mix();
    int len;
    while (words_sent < 1200) begin
      if ($urandom_range(0, 15) == 0) begin
        drain_results();
        write_idcode(rand_data());
      end
      gaps_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0, 1: scan_ir(pick_ir(), $urandom_range(0, 3) == 0);
        2, 3, 4: begin
          if (drive_ir == INSTR_DMI && $urandom_range(0, 4) != 0) begin
            scan_dr(dmi_frame(ADDR_BITS'(rand_data()), rand_data(),
                              dmi_op_t'($urandom_range(0, 3))),
                    DMI_LEN, $urandom_range(0, 3) == 0);
          end else begin
            len = $urandom_range(0, 1) ? dr_bits(drive_ir) : $urandom_range(1, 64);
            scan_dr({$urandom(), $urandom()}, len, $urandom_range(0, 3) == 0);
          end
        end
        5: put_word(OPC_RESP, $urandom_range(0, 1), $urandom_range(0, 1), rand_data());
        6: repeat ($urandom_range(1, 12)) tck($urandom_range(0, 1), $urandom_range(0, 1));
        7: repeat (5) tck(1'b1, $urandom_range(0, 1));
        default: begin
          if (drive_ir != INSTR_DMI) scan_ir(INSTR_DMI, 1'b0);
          repeat ($urandom_range(1, 3))
            scan_dr(dmi_frame(ADDR_BITS'(rand_data()), rand_data(),
                              dmi_op_t'($urandom_range(0, 3))),
                    DMI_LEN, $urandom_range(0, 3) == 0);
        end
      endcase
    end
    gaps_on = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n           <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.opcode    <= OPC_EDGE;
    in_if.tms       <= 1'b0;
    in_if.tdi       <= 1'b0;
    in_if.read_data <= '0;
    cfg_if.valid    <= 1'b0;
    cfg_if.data     <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_tap_walk();
    sprinkle_resp = 1'b1;
    test_idcode();
    test_dtmcs();
    test_bypass();
    test_dmi_access();
    test_input_stall();
    test_random_mix();

    // Every word has one registered result, so the quiet cycles after the
    // drain are enough to catch a stray result word.
    drain_results();
    repeat (5) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/jtdtm_pkg.sv
rtl/core/jtdtm_if.sv
rtl/core/jtdtm_tap_ctrl.sv
rtl/core/jtdtm_dr_unit.sv
rtl/core/jtag_tap_riscv_dtm_unit.sv
dv/jtag_tap_riscv_dtm_unit_tb.sv
